// ===== hw/rtl/lba_pkg.sv =====
// shared types, constants and status codes for the linked block allocator
`default_nettype none
package lba_pkg;
  localparam int DEF_NUM_BLOCKS = 256;
  localparam int DEF_DIR_SLOTS  = 16;
  localparam int REG_W          = 9;

  localparam logic       FUNC_CREATE  = 1'b0;
  localparam logic       FUNC_DELETE  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EXISTS    = 3'd1;
  localparam logic [2:0] ST_NO_SPACE  = 3'd2;
  localparam logic [2:0] ST_DIR_FULL  = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_BAD_COUNT = 3'd5;

  typedef struct packed {
    logic        func;
    logic [31:0] file_key;
    logic [8:0]  block_count;
  } lba_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] start_block;
    logic [8:0] free_blocks;
  } lba_out_t;
endpackage
`default_nettype wire

// ===== hw/rtl/lba_store.sv =====
// block store: used mark and next link per block, one write and one read port
`default_nettype none
module lba_store
  import lba_pkg::*;
#(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [$clog2(NUM_BLOCKS)-1:0]       waddr,
  input  wire logic [$clog2(NUM_BLOCKS)+1:0]       wdata,
  input  wire logic [$clog2(NUM_BLOCKS)-1:0]       raddr,
  output logic      [$clog2(NUM_BLOCKS)+1:0]       rdata
);
  localparam int BW = $clog2(NUM_BLOCKS);
  localparam int EW = BW + 2;

  logic [EW-1:0] mem [NUM_BLOCKS];
  logic [EW-1:0] mem_q_r;
  logic [EW-1:0] fwd_data_r;
  logic          fwd_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read with forwarding of a same-cycle write
  always_ff @(posedge clk) begin
    mem_q_r    <= mem[raddr];
    fwd_r      <= we && (waddr == raddr);
    fwd_data_r <= wdata;
  end

  assign rdata = fwd_r ? fwd_data_r : mem_q_r;
endmodule
`default_nettype wire

// ===== hw/rtl/lba_dir.sv =====
// file directory: key lookup, lowest free slot and slot updates
`default_nettype none
module lba_dir
  import lba_pkg::*;
#(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
  parameter int DIR_SLOTS  = DEF_DIR_SLOTS,
  localparam int BW = $clog2(NUM_BLOCKS),
  localparam int SW = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          clr_all,
  input  wire logic          set_en,
  input  wire logic          clr_en,
  input  wire logic [SW-1:0] wr_slot,
  input  wire logic [31:0]   wr_key,
  input  wire logic [BW-1:0] wr_start,
  input  wire logic [31:0]   look_key,
  output logic               hit,
  output logic [SW-1:0]      hit_slot,
  output logic [BW-1:0]      hit_start,
  output logic               free_found,
  output logic [SW-1:0]      free_slot
);
  logic [DIR_SLOTS-1:0] valid_r;
  logic [31:0]          key_r   [DIR_SLOTS];
  logic [BW-1:0]        start_r [DIR_SLOTS];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n || clr_all) begin
      valid_r <= '0;
    end else if (set_en) begin
      valid_r[wr_slot] <= 1'b1;
    end else if (clr_en) begin
      valid_r[wr_slot] <= 1'b0;
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    if (set_en) begin
      key_r[wr_slot]   <= wr_key;
      start_r[wr_slot] <= wr_start;
    end
  end

  // lowest matching slot and lowest empty slot
  always_comb begin
    hit        = 1'b0;
    hit_slot   = '0;
    free_found = 1'b0;
    free_slot  = '0;
    for (int s = DIR_SLOTS - 1; s >= 0; s--) begin
      if (valid_r[s] && key_r[s] == look_key) begin
        hit      = 1'b1;
        hit_slot = SW'(s);
      end
      if (!valid_r[s]) begin
        free_found = 1'b1;
        free_slot  = SW'(s);
      end
    end
    hit_start = start_r[hit_slot];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/linked_block_allocator_top.sv =====
// linked block allocator: request sequencer around the block store and directory
// the scan and the chain walk handle one block per cycle through the block store's single
// read port, so one request is in work at a time; reset and every blocks_in_use write run
// a clearing pass over every block of the block store, during which no transaction is accepted
`default_nettype none
module linked_block_allocator_top
  import lba_pkg::*;
#(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
  parameter int DIR_SLOTS  = DEF_DIR_SLOTS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire lba_in_t          in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output lba_out_t              out_data,
  input  wire logic             cfg_we,
  input  wire logic [REG_W-1:0] cfg_wdata
);
  localparam int BW = $clog2(NUM_BLOCKS);
  localparam int LW = BW + 1;
  localparam int CW = (LW > REG_W) ? LW : REG_W;
  localparam int SW = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
  localparam logic [LW-1:0] END_MARK = LW'(NUM_BLOCKS);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_CFIN  = 3'd4;
  localparam logic [2:0] S_DEL   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [REG_W-1:0] bin_r;
  logic [CW-1:0]    active;
  logic [CW-1:0]    free_r, free_nxt;
  logic [LW-1:0]    idx_r, idx_nxt;
  logic             rvld_r, rvld_nxt;
  logic [BW-1:0]    raddr_r, raddr_nxt;
  logic [BW-1:0]    prev_r, prev_nxt;
  logic [BW-1:0]    start_r, start_nxt;
  logic [CW-1:0]    taken_r, taken_nxt;
  logic [SW-1:0]    slot_r, slot_nxt;
  logic [2:0]       stat_r, stat_nxt;
  lba_in_t          req_r;
  logic             out_valid_r, out_valid_nxt;
  lba_out_t         out_r, out_nxt;

  logic             st_we;
  logic [BW-1:0]    st_waddr, st_raddr;
  logic [LW:0]      st_wdata, st_rdata;
  logic             blk_used;
  logic [LW-1:0]    blk_link;

  logic             dir_set, dir_clr;
  logic             hit, free_found;
  logic [SW-1:0]    hit_slot, free_slot;
  logic [BW-1:0]    hit_start;

  assign active   = (CW'(bin_r) < CW'(NUM_BLOCKS)) ? CW'(bin_r) : CW'(NUM_BLOCKS);
  assign blk_used = st_rdata[LW];
  assign blk_link = st_rdata[LW-1:0];

  lba_store #(.NUM_BLOCKS(NUM_BLOCKS)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  lba_dir #(.NUM_BLOCKS(NUM_BLOCKS), .DIR_SLOTS(DIR_SLOTS)) u_dir (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr_all    (cfg_we),
    .set_en     (dir_set),
    .clr_en     (dir_clr),
    .wr_slot    (slot_r),
    .wr_key     (req_r.file_key),
    .wr_start   (start_r),
    .look_key   (req_r.file_key),
    .hit        (hit),
    .hit_slot   (hit_slot),
    .hit_start  (hit_start),
    .free_found (free_found),
    .free_slot  (free_slot)
  );

  // request sequencer
  always_comb begin
    state_nxt     = state_r;
    free_nxt      = free_r;
    idx_nxt       = idx_r;
    rvld_nxt      = 1'b0;
    raddr_nxt     = raddr_r;
    prev_nxt      = prev_r;
    start_nxt     = start_r;
    taken_nxt     = taken_r;
    slot_nxt      = slot_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    st_we         = 1'b0;
    st_waddr      = '0;
    st_wdata      = {1'b0, END_MARK};
    st_raddr      = '0;
    dir_set       = 1'b0;
    dir_clr       = 1'b0;
    unique case (state_r)
      S_CLR: begin
        st_we    = 1'b1;
        st_waddr = idx_r[BW-1:0];
        idx_nxt  = idx_r + 1'b1;
        if (idx_r == LW'(NUM_BLOCKS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        start_nxt = '0;
        taken_nxt = '0;
        idx_nxt   = '0;
        if (req_r.func == FUNC_DELETE) begin
          slot_nxt = hit_slot;
          if (!hit) begin
            stat_nxt  = ST_NOT_FOUND;
            state_nxt = S_DONE;
          end else begin
            stat_nxt  = ST_OK;
            start_nxt = hit_start;
            raddr_nxt = hit_start;
            st_raddr  = hit_start;
            if (CW'(hit_start) < active) begin
              state_nxt = S_DEL;
            end else begin
              dir_clr   = 1'b1;
              state_nxt = S_DONE;
            end
          end
        end else begin
          slot_nxt  = free_slot;
          state_nxt = S_DONE;
          priority if (hit) begin
            stat_nxt = ST_EXISTS;
          end else if (req_r.block_count == '0) begin
            stat_nxt = ST_BAD_COUNT;
          end else if (CW'(req_r.block_count) > free_r) begin
            stat_nxt = ST_NO_SPACE;
          end else if (!free_found) begin
            stat_nxt = ST_DIR_FULL;
          end else begin
            stat_nxt  = ST_OK;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // issue the next read while the previous one is checked
        st_raddr = idx_r[BW-1:0];
        if (CW'(idx_r) < active) begin
          rvld_nxt  = 1'b1;
          raddr_nxt = idx_r[BW-1:0];
          idx_nxt   = idx_r + 1'b1;
        end
        if (rvld_r && !blk_used) begin
          taken_nxt = taken_r + 1'b1;
          prev_nxt  = raddr_r;
          if (taken_r == '0) begin
            start_nxt = raddr_r;
          end else begin
            st_we    = 1'b1;
            st_waddr = prev_r;
            st_wdata = {1'b1, LW'(raddr_r)};
          end
          if (taken_r + 1'b1 == CW'(req_r.block_count)) begin
            state_nxt = S_CFIN;
          end
        end else if (!rvld_r && !(CW'(idx_r) < active)) begin
          state_nxt = S_CFIN;
        end
      end
      S_CFIN: begin
        st_we     = 1'b1;
        st_waddr  = prev_r;
        st_wdata  = {1'b1, END_MARK};
        free_nxt  = free_r - taken_r;
        dir_set   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DEL: begin
        // free the block read last cycle and follow its link
        st_we    = 1'b1;
        st_waddr = raddr_r;
        st_raddr = blk_link[BW-1:0];
        if (blk_used) begin
          free_nxt = free_r + 1'b1;
        end
        taken_nxt = taken_r + 1'b1;
        raddr_nxt = blk_link[BW-1:0];
        if (!(CW'(blk_link) < active && taken_r + 1'b1 < CW'(NUM_BLOCKS))) begin
          dir_clr   = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt       = 1'b1;
          out_nxt.status      = stat_r;
          out_nxt.start_block = (stat_r == ST_OK) ? 8'(CW'(start_r)) : 8'd0;
          out_nxt.free_blocks = free_r[REG_W-1:0];
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      bin_r       <= REG_W'(256);
      free_r      <= (CW'(256) < CW'(NUM_BLOCKS)) ? CW'(256) : CW'(NUM_BLOCKS);
      idx_r       <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (cfg_we) begin
      state_r     <= S_CLR;
      bin_r       <= cfg_wdata;
      free_r      <= (CW'(cfg_wdata) < CW'(NUM_BLOCKS)) ? CW'(cfg_wdata) : CW'(NUM_BLOCKS);
      idx_r       <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= out_valid_nxt;
    end else begin
      state_r     <= state_nxt;
      free_r      <= free_nxt;
      idx_r       <= idx_nxt;
      rvld_r      <= rvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and working payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    raddr_r <= raddr_nxt;
    prev_r  <= prev_nxt;
    start_r <= start_nxt;
    taken_r <= taken_nxt;
    slot_r  <= slot_nxt;
    stat_r  <= stat_nxt;
    out_r   <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

// ===== hw/rtl/lba_checker.sv =====
// port-level checks for the linked block allocator, bound to the top level
`default_nettype none
module lba_checker
  import lba_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire lba_out_t out_data
);
  // a result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // one request in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted during work");

  // failed requests report start block zero
  a_fail_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.start_block == 8'd0)
    else $error("nonzero start block on failure");

  // status is a defined code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_BAD_COUNT)
    else $error("undefined status code");

  // free count never exceeds the store
  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.free_blocks <= 9'd256)
    else $error("free count out of range");
endmodule

bind linked_block_allocator_top lba_checker u_lba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// ===== tb/sv/lba_checker.sv =====
// checker for the linked block allocator: watches both channels, predicts and compares
module lba_scoreboard
  import lba_pkg::*;
#(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
  parameter int DIR_SLOTS  = DEF_DIR_SLOTS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  lba_in_t          in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  lba_out_t         out_data,
  input  logic             cfg_we,
  input  logic [REG_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int END_MARK = NUM_BLOCKS;

  // mirror of the block store and directory
  bit          blk_used [NUM_BLOCKS];
  int          blk_link [NUM_BLOCKS];
  bit          slot_valid [DIR_SLOTS];
  logic [31:0] slot_key [DIR_SLOTS];
  int          slot_start [DIR_SLOTS];
  int          free_left;
  int          managed;
  lba_out_t    expected_results [$];

  assign pending = expected_results.size();

  function automatic void wipe_store(input logic [REG_W-1:0] value);
    managed = (value < NUM_BLOCKS) ? int'(value) : NUM_BLOCKS;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      blk_used[i] = 0;
      blk_link[i] = END_MARK;
    end
    for (int s = 0; s < DIR_SLOTS; s++) begin
      slot_valid[s] = 0;
      slot_key[s] = '0;
      slot_start[s] = 0;
    end
    free_left = managed;
  endfunction

  function automatic int lookup_slot(input logic [31:0] key);
    for (int s = 0; s < DIR_SLOTS; s++)
      if (slot_valid[s] && slot_key[s] == key) return s;
    return -1;
  endfunction

  // allocate or release one file and return the expected reply
  function automatic lba_out_t allocate_or_free(input lba_in_t req);
    lba_out_t res;
    int slot, prev, taken, cur, nxt, steps, first;
    res = '0;
    first = 0;
    slot = lookup_slot(req.file_key);
    if (req.func == FUNC_CREATE) begin
      if (slot >= 0) res.status = ST_EXISTS;
      else if (req.block_count == 0) res.status = ST_BAD_COUNT;
      else if (int'(req.block_count) > free_left) res.status = ST_NO_SPACE;
      else begin
        slot = -1;
        for (int s = 0; s < DIR_SLOTS; s++)
          if (!slot_valid[s] && slot < 0) slot = s;
        if (slot < 0) res.status = ST_DIR_FULL;
        else begin
          prev = 0;
          taken = 0;
          for (int i = 0; i < managed && taken < int'(req.block_count); i++) begin
            if (!blk_used[i]) begin
              blk_used[i] = 1;
              if (taken == 0) first = i;
              else blk_link[prev] = i;
              prev = i;
              taken++;
            end
          end
          if (taken > 0) blk_link[prev] = END_MARK;
          free_left -= taken;
          slot_valid[slot] = 1;
          slot_key[slot] = req.file_key;
          slot_start[slot] = first;
          res.status = ST_OK;
        end
      end
    end else begin
      if (slot < 0) res.status = ST_NOT_FOUND;
      else begin
        cur = slot_start[slot];
        first = cur;
        steps = 0;
        while (cur < managed && steps < NUM_BLOCKS) begin
          nxt = blk_link[cur];
          if (blk_used[cur]) begin
            blk_used[cur] = 0;
            free_left++;
          end
          blk_link[cur] = END_MARK;
          cur = nxt;
          steps++;
        end
        slot_valid[slot] = 0;
        res.status = ST_OK;
      end
    end
    res.start_block = (res.status == ST_OK) ? first[7:0] : 8'd0;
    res.free_blocks = free_left[8:0];
    return res;
  endfunction

  // track config, predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    lba_out_t want;
    if (!rst_n) begin
      wipe_store(9'd256);
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) wipe_store(cfg_wdata);
      if (in_valid && in_ready) expected_results.push_back(allocate_or_free(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want !== out_data) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb_top.sv =====
// testbench top for the linked block allocator: stimulus, stalls and verdict
module tb_top;
  import lba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk = 0;
  logic             rst_n = 0;
  logic             in_valid = 0;
  logic             in_ready;
  lba_in_t          in_data = '0;
  logic             out_valid;
  logic             out_ready = 0;
  lba_out_t         out_data;
  logic             cfg_we = 0;
  logic [REG_W-1:0] cfg_wdata = '0;
  int               fail_count;
  int               pending;
  int               cycle_count = 0;
  bit               hold_off = 0;
  logic [31:0]      key_pool [8];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  linked_block_allocator_top dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  lba_scoreboard chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // receiver stalls, with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_off || (cycle_count % 3000 > 1500 && $urandom_range(0, 1))) out_ready <= 0;
    else out_ready <= ($urandom_range(0, 4) != 0);
  end

  // timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1500000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one input transaction, with a random gap before it; valid stays up when there is no gap
  task automatic send(input logic f, input logic [31:0] key, input logic [8:0] cnt);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{func: f, file_key: key, block_count: cnt};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_blocks(input logic [8:0] value);
    drain();
    cfg_we <= 1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_phase(input int n, input int maxc);
    logic [31:0] key;
    for (int i = 0; i < n; i++) begin
      key = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 1)) send(FUNC_DELETE, key, 9'($urandom()));
      else send(FUNC_CREATE, key, ($urandom_range(0, 15) == 0) ? 9'($urandom())
                                  : 9'($urandom_range(0, maxc)));
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    // directed: extremes, every status, broken paths
    send(FUNC_CREATE, 32'h0, 9'd0);
    send(FUNC_CREATE, 32'h0, 9'd3);
    send(FUNC_CREATE, 32'h0, 9'd1);
    send(FUNC_CREATE, 32'hFFFF_FFFF, 9'd257);
    send(FUNC_CREATE, 32'hFFFF_FFFF, 9'd253);
    send(FUNC_DELETE, 32'h1234_5678, 9'd0);
    send(FUNC_DELETE, 32'h0, 9'h1FF);
    send(FUNC_CREATE, 32'hA5A5_5A5A, 9'd2);
    send(FUNC_DELETE, 32'hFFFF_FFFF, 9'd0);
    for (int i = 0; i < 17; i++) send(FUNC_CREATE, 32'h100 + i, 9'd1);
    write_blocks(9'd0);
    send(FUNC_CREATE, 32'h5, 9'd1);
    send(FUNC_CREATE, 32'h6, 9'd0);
    // long receiver hold-off while requests keep coming
    hold_off <= 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off <= 0;
      end
      random_phase(10, 3);
    join
    write_blocks(9'd1);
    random_phase(40, 2);
    write_blocks(9'd511);
    random_phase(120, 64);
    write_blocks(9'd256);
    random_phase(120, 40);
    write_blocks(9'd20);
    random_phase(120, 6);
    drain();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
